FILE: rtl/core/cbd_pkg.sv
// Package for the chunked HTTP body decoder.
// Item types, result kinds and reset constants; no dependencies.

package cbd_pkg;

  // Default width of the chunk size accumulator
  localparam int unsigned DEF_SIZE_WIDTH = 32;

  // Reset value and width of the size-line digit limit register
  localparam int unsigned LIMIT_W = 4;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd6;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_DONE = 2'd1,
    KIND_BAD  = 2'd2
  } kind_e;

  // One raw input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_message;
  } in_item_t;

  // One result item
  typedef struct packed {
    kind_e      result_kind;
    logic [7:0] body_byte;
  } out_item_t;

endpackage

FILE: rtl/core/cbd_in_stage.sv
// Input register of the chunked body decoder.
// Holds one accepted item until the parser takes it; uses cbd_pkg.

module cbd_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  cbd_pkg::in_item_t in_item_i,
  output logic              in_stall_o,
  input  logic              take_i,
  output logic              held_valid_o,
  output cbd_pkg::in_item_t held_item_o
);
  import cbd_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     accept;

  // Stall only when the held item cannot move on this cycle
  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  assign held_valid_o = valid_q;
  assign held_item_o  = item_q;

endmodule

FILE: rtl/core/cbd_parser.sv
// Chunk framing parser: parser state and the per-byte update.
// One item is consumed per enabled cycle; uses cbd_pkg.

module cbd_parser #(
  parameter int unsigned SIZE_WIDTH = cbd_pkg::DEF_SIZE_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  cbd_pkg::in_item_t             item_i,
  input  logic [cbd_pkg::LIMIT_W-1:0]   limit_i,
  output logic                          res_valid_o,
  output cbd_pkg::out_item_t            res_item_o
);
  import cbd_pkg::*;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // Framing phase, one-hot
  typedef enum logic [3:0] {
    PH_SIZE     = 4'b0001,
    PH_DATA     = 4'b0010,
    PH_DATA_END = 4'b0100,
    PH_LAST_END = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2
  } status_e;

  phase_e                phase_q, phase_d, ph;
  logic [SIZE_WIDTH-1:0] rem_q, rem_d, rem, rem_dec;
  logic [3:0]            cnt_q, cnt_d, cnt;
  logic                  term_q, term_d, term;
  status_e               stat_q, stat_d, stat;
  logic [3:0]            lim;
  logic                  is_hex;
  logic [3:0]            hex_val;
  logic                  bad;
  logic [7:0]            c;

  // Hex digit decode
  always_comb begin
    c       = item_i.data_byte;
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      hex_val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      hex_val = 4'(c - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
  end

  // Digit limit clamped to 1..8
  always_comb begin
    if (limit_i == '0) begin
      lim = 4'd1;
    end else if (limit_i > 4'd8) begin
      lim = 4'd8;
    end else begin
      lim = limit_i;
    end
  end

  // State as seen by this item: a new message starts from clear state
  always_comb begin
    if (item_i.new_message) begin
      ph   = PH_SIZE;
      rem  = '0;
      cnt  = 4'd0;
      term = 1'b0;
      stat = ST_NONE;
    end else begin
      ph   = phase_q;
      rem  = rem_q;
      cnt  = cnt_q;
      term = term_q;
      stat = stat_q;
    end
  end

  assign rem_dec = rem - 1'b1;

  // Per-byte framing step
  always_comb begin
    phase_d     = ph;
    rem_d       = rem;
    cnt_d       = cnt;
    term_d      = term;
    stat_d      = stat;
    bad         = 1'b0;
    res_valid_o = 1'b0;
    res_item_o  = '{result_kind: KIND_BYTE, body_byte: 8'd0};
    if (stat == ST_NONE) begin
      unique case (ph)
        PH_SIZE: begin
          if (term) begin
            if (c != CHAR_LF) begin
              bad = 1'b1;
            end else begin
              term_d = 1'b0;
              cnt_d  = 4'd0;
              if (rem == '0) begin
                if (cnt != 4'd1) begin
                  bad = 1'b1;
                end else begin
                  phase_d = PH_LAST_END;
                end
              end else begin
                phase_d = PH_DATA;
              end
            end
          end else if (c == CHAR_CR) begin
            if (cnt == 4'd0) begin
              bad = 1'b1;
            end else begin
              term_d = 1'b1;
            end
          end else if (!is_hex || cnt >= lim || (|rem[SIZE_WIDTH-1 -: 4])) begin
            bad = 1'b1;
          end else begin
            rem_d = {rem[SIZE_WIDTH-5:0], hex_val};
            cnt_d = cnt + 4'd1;
          end
        end
        PH_DATA: begin
          rem_d = rem_dec;
          if (rem_dec == '0) begin
            phase_d = PH_DATA_END;
          end
          res_valid_o = 1'b1;
          res_item_o  = '{result_kind: KIND_BYTE, body_byte: c};
        end
        PH_DATA_END, PH_LAST_END: begin
          if (!term) begin
            if (c != CHAR_CR) begin
              bad = 1'b1;
            end else begin
              term_d = 1'b1;
            end
          end else if (c != CHAR_LF) begin
            bad = 1'b1;
          end else begin
            term_d = 1'b0;
            if (ph == PH_LAST_END) begin
              stat_d      = ST_DONE;
              res_valid_o = 1'b1;
              res_item_o  = '{result_kind: KIND_DONE, body_byte: 8'd0};
            end else begin
              phase_d = PH_SIZE;
              rem_d   = '0;
              cnt_d   = 4'd0;
            end
          end
        end
        default: begin
          bad = 1'b1;
        end
      endcase
      // Framing fault: one bad-request result, then silent
      if (bad) begin
        stat_d      = ST_ERROR;
        res_valid_o = 1'b1;
        res_item_o  = '{result_kind: KIND_BAD, body_byte: 8'd0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIZE;
      rem_q   <= '0;
      cnt_q   <= 4'd0;
      term_q  <= 1'b0;
      stat_q  <= ST_NONE;
    end else if (en_i) begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
      term_q  <= term_d;
      stat_q  <= stat_d;
    end
  end

  // A finished or failed message stays silent until restarted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && stat_q != ST_NONE && !item_i.new_message) |-> !res_valid_o)
    else $error("cbd_parser: result after completion or error");

  // Data phase always has bytes still due
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (rem_q != '0))
    else $error("cbd_parser: data phase with zero bytes remaining");

endmodule

FILE: rtl/core/cbd_out_stage.sv
// Result register of the chunked body decoder.
// Holds one result until the receiver takes it; uses cbd_pkg.

module cbd_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  cbd_pkg::out_item_t item_i,
  output logic               ready_o,
  output logic               out_valid_o,
  output cbd_pkg::out_item_t out_item_o,
  input  logic               out_stall_i
);
  import cbd_pkg::*;

  logic      valid_q, valid_d;
  out_item_t item_q;

  // Free, or emptying this cycle
  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

FILE: rtl/core/http_chunked_body_decoder_unit.sv
// Chunked HTTP body decoder, top level.
// Input register, framing parser and result register; uses cbd_pkg.
//
// Usage: raw body bytes enter on the in_* channel, one byte per item, with
// new_message set on the first byte of each body. Each data byte comes out
// as a KIND_BYTE item on the out_* channel; a well-formed final chunk gives
// one KIND_DONE item and a framing fault gives one KIND_BAD item. After
// either, bytes give no result until new_message is seen again.
// Path: an accepted item waits in the input register; it is parsed when
// the result register can take a result, and any result it gives is loaded
// there and offered on the out_* channel.
// Throughput: one item per cycle while the receiver does not stall; the
// parser state update per byte is the only loop.
// Stall: while the receiver stalls a waiting result, one more item is still
// accepted into the input register; only then is in_stall_o raised.
// Reset: parser returns to the size line with no error, both registers
// empty, and the digit limit goes to 6. The cfg channel writes the digit
// limit and is always ready; write it only while no item is in flight.

module http_chunked_body_decoder_unit #(
  parameter int unsigned SIZE_WIDTH = cbd_pkg::DEF_SIZE_WIDTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  cbd_pkg::in_item_t           in_item_i,
  output logic                        in_stall_o,
  output logic                        out_valid_o,
  output cbd_pkg::out_item_t          out_item_o,
  input  logic                        out_stall_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [cbd_pkg::LIMIT_W-1:0] cfg_data_i
);
  import cbd_pkg::*;

  logic [LIMIT_W-1:0] limit_q;
  logic               held_valid;
  in_item_t           held_item;
  logic               out_ready;
  logic               advance;
  logic               res_valid;
  out_item_t          res_item;

  // Digit limit register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  // Held item moves on whenever the result register can take a result
  assign advance = held_valid && out_ready;

  cbd_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_item_i    (in_item_i),
    .in_stall_o   (in_stall_o),
    .take_i       (advance),
    .held_valid_o (held_valid),
    .held_item_o  (held_item)
  );

  cbd_parser #(
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .item_i      (held_item),
    .limit_i     (limit_q),
    .res_valid_o (res_valid),
    .res_item_o  (res_item)
  );

  cbd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && res_valid),
    .item_i      (res_item),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

  // Back-pressure only arises from a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("cbd: input stalled without output back-pressure");

  // Only body bytes carry a payload byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.result_kind != KIND_BYTE) |-> (out_item_o.body_byte == 8'd0))
    else $error("cbd: non-byte result with nonzero payload");

endmodule
